>>> hw/rtl/pre_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pre_pkg: shared types and constants of the printable run extractor
// Request layouts, command codes between front and back, the truncation note.
// ----------------------------------------------------------------------------
package pre_pkg;

	localparam int MAX_HOLD_DEF = 16;

	// Configuration register indexes
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_LENGTH   = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_LIMIT = 1'b1;
	localparam int CFG_DATA_W = 32;

	localparam logic [4:0]  MIN_LENGTH_RST   = 5'd4;
	localparam logic [31:0] OUTPUT_LIMIT_RST = 32'd10485760;

	// Position / count width, covers MAX_HOLD up to 64 and the note length
	localparam int CNT_W = 7;
	// Width used when comparing run length against the minimum
	localparam int CMP_W = 8;

	localparam logic [7:0] CHAR_NL  = 8'h0A;
	localparam logic [7:0] CHAR_TAB = 8'h09;

	localparam int NOTE_LEN = 30;
	localparam logic [NOTE_LEN*8-1:0] NOTE = "\n[Truncated - File too large]\n";

	// Command queue depth (power of two)
	localparam int CQ_DEPTH = 4;

	// Command codes
	localparam logic [1:0] OP_BYTE  = 2'd0; // emit data
	localparam logic [1:0] OP_BURST = 2'd1; // emit held bytes, then data
	localparam logic [1:0] OP_NL    = 2'd2; // end of run newline, flag = truncate
	localparam logic [1:0] OP_EOF   = 2'd3; // end of file, flag = run qualified

	typedef struct packed {
		logic       kind;
		logic [7:0] data;
	} item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       has_byte;
		logic       last_of_item;
		logic       end_of_stream;
	} result_t;

	typedef struct packed {
		logic [1:0]       op;
		logic [7:0]       data;
		logic [CNT_W-1:0] cnt;
		logic             flag;
	} cmd_t;

	typedef struct packed {
		logic             we;
		logic [CNT_W-1:0] addr;
		logic [7:0]       data;
	} hold_wr_t;

	function automatic logic [7:0] note_char(input logic [4:0] idx);
		logic [4:0] sel;
		sel = 5'(NOTE_LEN - 1) - idx;
		return NOTE[{sel, 3'b000} +: 8];
	endfunction

endpackage
`default_nettype wire

>>> hw/rtl/pre_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pre_front: input classifier
// Tracks run state and output count, writes held bytes, issues commands.
// ----------------------------------------------------------------------------
module pre_front #(
	parameter int MAX_HOLD = pre_pkg::MAX_HOLD_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            push,
	output logic                                 full,
	input  wire pre_pkg::item_t                  item,
	input  wire logic                            cfg_we,
	input  wire logic [pre_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [pre_pkg::CFG_DATA_W-1:0]  cfg_data,
	output logic                                 cq_push,
	output pre_pkg::cmd_t                        cq_cmd,
	input  wire logic                            cq_full,
	output pre_pkg::hold_wr_t                    hold_wr,
	input  wire logic                            burst_done
);
	localparam int HW = $clog2(MAX_HOLD + 1);
	localparam logic [pre_pkg::CMP_W-1:0] MAX_C = pre_pkg::CMP_W'(MAX_HOLD);

	logic [4:0]   min_length_q;
	logic [31:0]  output_limit_q;
	logic [HW-1:0] run_length_q;
	logic         qualified_q;
	logic [32:0]  count_q;
	logic         stopped_q;
	logic         busy_q;

	logic         accept;
	logic         text;
	logic [pre_pkg::CMP_W-1:0] eff_min, rl_c;
	logic         release_run;
	logic [pre_pkg::CNT_W-1:0] inc;
	logic [33:0]  sum;
	logic [32:0]  count_next;
	logic         trunc;

	assign full   = !stopped_q && (cq_full || (busy_q && !qualified_q));
	assign accept = push && !full && !stopped_q;
	assign text   = (item.data >= 8'h20 && item.data <= 8'h7E) ||
		item.data == pre_pkg::CHAR_NL || item.data == pre_pkg::CHAR_TAB;

	always_comb begin
		eff_min = pre_pkg::CMP_W'(min_length_q);
		if (min_length_q == 5'd0) begin
			eff_min = pre_pkg::CMP_W'(1);
		end
		if (eff_min > MAX_C) begin
			eff_min = MAX_C;
		end
	end

	assign rl_c        = pre_pkg::CMP_W'(run_length_q);
	assign release_run = (rl_c + pre_pkg::CMP_W'(1) >= eff_min) || (rl_c >= MAX_C);

	// bytes this item emits: one, or the held head plus the new byte
	assign inc = (!item.kind && text && !qualified_q) ?
		pre_pkg::CNT_W'(run_length_q) + pre_pkg::CNT_W'(1) : pre_pkg::CNT_W'(1);
	assign sum        = {1'b0, count_q} + 34'(inc);
	assign count_next = sum[33] ? {33{1'b1}} : sum[32:0];
	assign trunc      = count_next > {1'b0, output_limit_q};

	always_comb begin
		cq_push       = 1'b0;
		cq_cmd.op     = pre_pkg::OP_BYTE;
		cq_cmd.data   = item.data;
		cq_cmd.cnt    = pre_pkg::CNT_W'(run_length_q);
		cq_cmd.flag   = 1'b0;
		hold_wr.we    = 1'b0;
		hold_wr.addr  = pre_pkg::CNT_W'(run_length_q);
		hold_wr.data  = item.data;
		if (accept) begin
			if (item.kind) begin
				cq_push     = 1'b1;
				cq_cmd.op   = pre_pkg::OP_EOF;
				cq_cmd.flag = qualified_q;
			end else if (text) begin
				if (qualified_q) begin
					cq_push   = 1'b1;
					cq_cmd.op = pre_pkg::OP_BYTE;
				end else if (release_run) begin
					cq_push   = 1'b1;
					cq_cmd.op = pre_pkg::OP_BURST;
				end else begin
					hold_wr.we = 1'b1;
				end
			end else if (qualified_q) begin
				cq_push     = 1'b1;
				cq_cmd.op   = pre_pkg::OP_NL;
				cq_cmd.flag = trunc;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_length_q   <= pre_pkg::MIN_LENGTH_RST;
			output_limit_q <= pre_pkg::OUTPUT_LIMIT_RST;
		end else if (cfg_we) begin
			if (cfg_index == pre_pkg::CFG_MIN_LENGTH) begin
				min_length_q <= cfg_data[4:0];
			end else begin
				output_limit_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_length_q <= '0;
			qualified_q  <= 1'b0;
			count_q      <= '0;
			stopped_q    <= 1'b0;
			busy_q       <= 1'b0;
		end else begin
			if (burst_done) begin
				busy_q <= 1'b0;
			end
			if (accept) begin
				if (item.kind) begin
					stopped_q    <= 1'b1;
					run_length_q <= '0;
					qualified_q  <= 1'b0;
				end else if (text) begin
					if (qualified_q) begin
						count_q <= count_next;
					end else if (release_run) begin
						count_q      <= count_next;
						run_length_q <= '0;
						qualified_q  <= 1'b1;
						busy_q       <= (run_length_q != '0);
					end else begin
						run_length_q <= run_length_q + HW'(1);
					end
				end else begin
					if (qualified_q) begin
						count_q <= count_next;
						if (trunc) begin
							stopped_q <= 1'b1;
						end
					end
					run_length_q <= '0;
					qualified_q  <= 1'b0;
				end
			end
		end
	end

endmodule
`default_nettype wire

>>> hw/rtl/pre_cmd_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pre_cmd_queue: command queue
// Small first-in first-out buffer between the classifier and the emitter.
// ----------------------------------------------------------------------------
module pre_cmd_queue (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire pre_pkg::cmd_t din,
	output logic               full,
	input  wire logic          pop,
	output pre_pkg::cmd_t      dout,
	output logic               empty
);
	localparam int AW = $clog2(pre_pkg::CQ_DEPTH);

	pre_pkg::cmd_t mem_q [pre_pkg::CQ_DEPTH];
	logic [AW-1:0] wr_q, rd_q;
	logic [AW:0]   level_q;
	logic          do_push, do_pop;

	assign full    = level_q == (AW + 1)'(pre_pkg::CQ_DEPTH);
	assign empty   = level_q == '0;
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign dout    = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			level_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= wr_q + AW'(1);
			end
			if (do_pop) begin
				rd_q <= rd_q + AW'(1);
			end
			case ({do_push, do_pop})
				2'b10:   level_q <= level_q + (AW + 1)'(1);
				2'b01:   level_q <= level_q - (AW + 1)'(1);
				default: level_q <= level_q;
			endcase
		end
	end

endmodule
`default_nettype wire

>>> hw/rtl/pre_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pre_back: result emitter
// Holds the run head, expands commands into result bytes, output register.
// ----------------------------------------------------------------------------
module pre_back #(
	parameter int MAX_HOLD = pre_pkg::MAX_HOLD_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire pre_pkg::hold_wr_t hold_wr,
	input  wire pre_pkg::cmd_t     cq_cmd,
	input  wire logic              cq_empty,
	output logic                   cq_pop,
	output logic                   burst_done,
	output pre_pkg::result_t       result,
	output logic                   empty,
	input  wire logic              pop
);
	localparam int IW = (MAX_HOLD > 1) ? $clog2(MAX_HOLD) : 1;

	logic [7:0] hold_q [MAX_HOLD];

	pre_pkg::cmd_t              cmd_q;
	logic [pre_pkg::CNT_W-1:0]  pos_q;
	logic                       active_q;
	pre_pkg::result_t           out_q;
	logic                       out_valid_q;

	pre_pkg::cmd_t              src;
	logic [pre_pkg::CNT_W-1:0]  src_pos, pos_m1;
	logic                       have, load, fire;
	pre_pkg::result_t           r;

	always_ff @(posedge clk) begin
		if (hold_wr.we) begin
			hold_q[hold_wr.addr[IW-1:0]] <= hold_wr.data;
		end
	end

	assign src     = active_q ? cmd_q : cq_cmd;
	assign src_pos = active_q ? pos_q : '0;
	assign pos_m1  = src_pos - pre_pkg::CNT_W'(1);
	assign have    = active_q || !cq_empty;
	assign load    = !out_valid_q || pop;
	assign fire    = load && have;

	always_comb begin
		r.out_byte      = 8'h00;
		r.has_byte      = 1'b1;
		r.last_of_item  = 1'b1;
		r.end_of_stream = 1'b0;
		case (src.op)
			pre_pkg::OP_BYTE: begin
				r.out_byte = src.data;
			end
			pre_pkg::OP_BURST: begin
				if (src_pos < src.cnt) begin
					r.out_byte     = hold_q[src_pos[IW-1:0]];
					r.last_of_item = 1'b0;
				end else begin
					r.out_byte = src.data;
				end
			end
			pre_pkg::OP_NL: begin
				if (src_pos == '0) begin
					r.out_byte     = pre_pkg::CHAR_NL;
					r.last_of_item = !src.flag;
				end else begin
					r.out_byte      = pre_pkg::note_char(pos_m1[4:0]);
					r.last_of_item  = src_pos == pre_pkg::CNT_W'(pre_pkg::NOTE_LEN);
					r.end_of_stream = r.last_of_item;
				end
			end
			pre_pkg::OP_EOF: begin
				r.has_byte      = src.flag;
				r.out_byte      = src.flag ? pre_pkg::CHAR_NL : 8'h00;
				r.end_of_stream = 1'b1;
			end
			default: begin
				r.has_byte = 1'b0;
			end
		endcase
	end

	assign cq_pop     = fire && !active_q;
	assign burst_done = fire && r.last_of_item && src.op == pre_pkg::OP_BURST;
	assign result     = out_q;
	assign empty      = !out_valid_q;

	always_ff @(posedge clk) begin
		if (fire) begin
			out_q <= r;
			cmd_q <= src;
			pos_q <= src_pos + pre_pkg::CNT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= have;
			if (have) begin
				active_q <= !r.last_of_item;
			end
		end
	end

endmodule
`default_nettype wire

>>> hw/rtl/printable_run_extractor_top.sv
`timescale 1ns / 1ps
`default_nettype none
// A result request reaches the result port from the input request that causes
//   it through the command queue, then the output register.
// Throughput: one input and one result request per cycle while not full and popped;
//   a run head release or the truncation note emits one held byte / note byte per cycle.
// After a release with held bytes, the next run's first byte waits until the
//   burst has left the emitter. Asynchronous reset clears all control state.
// ----------------------------------------------------------------------------
// printable_run_extractor_top: printable run extractor
// Scans a byte stream and emits text runs of at least min_length bytes (zero acts as one, at most MAX_HOLD), each
// terminated by a newline, with a truncation note past output_limit.
// ----------------------------------------------------------------------------
module printable_run_extractor_top #(
	parameter int MAX_HOLD = pre_pkg::MAX_HOLD_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	// input request queue side
	input  wire logic                           push,
	output logic                                full,
	input  wire pre_pkg::item_t                 item,
	// result queue side
	output logic                                empty,
	input  wire logic                           pop,
	output pre_pkg::result_t                    result,
	// configuration write port
	input  wire logic                           cfg_we,
	input  wire logic [pre_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [pre_pkg::CFG_DATA_W-1:0] cfg_data
);
	// front -> queue
	logic              cq_push;
	pre_pkg::cmd_t     cq_in;
	logic              cq_full;
	// queue -> back
	pre_pkg::cmd_t     cq_out;
	logic              cq_empty;
	logic              cq_pop;
	// front -> back: run head writes; back -> front: burst has drained
	pre_pkg::hold_wr_t hold_wr;
	logic              burst_done;

	// Classifier: owns config, run state, emitted byte count and stop flag.
	pre_front #(
		.MAX_HOLD(MAX_HOLD)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.item       (item),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.cq_push    (cq_push),
		.cq_cmd     (cq_in),
		.cq_full    (cq_full),
		.hold_wr    (hold_wr),
		.burst_done (burst_done)
	);

	// Decouples classification from multi-byte expansion.
	pre_cmd_queue u_cmd_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (cq_push),
		.din    (cq_in),
		.full   (cq_full),
		.pop    (cq_pop),
		.dout   (cq_out),
		.empty  (cq_empty)
	);

	// Emitter: one result byte per cycle into the output register while it is empty or popped.
	pre_back #(
		.MAX_HOLD(MAX_HOLD)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.hold_wr    (hold_wr),
		.cq_cmd     (cq_out),
		.cq_empty   (cq_empty),
		.cq_pop     (cq_pop),
		.burst_done (burst_done),
		.result     (result),
		.empty      (empty),
		.pop        (pop)
	);

endmodule
`default_nettype wire

>>> tb/printable_run_extractor_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// printable_run_extractor_top_test: self-checking bench for the run extractor
// Feeds file bytes through the request queue with random gaps, pops results
// under a changing stall pattern and checks every result against a scoreboard
// that predicts text runs, held-head bursts, newlines, truncation and EOF.
// ----------------------------------------------------------------------------
module printable_run_extractor_top_test;

	localparam int HOLD_DEPTH  = pre_pkg::MAX_HOLD_DEF;
	localparam int STALL_LIMIT = 2000;	// cycles with no request moving either way
	localparam int SETTLE_CYC  = 16;	// covers quiet requests still in the pipe

	// Scoreboard: predicts results of accepted input requests and checks pops.
	class run_scoreboard;
		logic [4:0]       min_len;
		logic [31:0]      out_limit;
		logic [7:0]       head[HOLD_DEPTH];
		int unsigned      held;
		bit               passing;	// current run qualified, bytes flow through
		logic [32:0]      emitted;
		bit               stopped;
		pre_pkg::result_t pending_results[$];
		pre_pkg::result_t this_item[$];
		int               errors;

		function new();
			min_len   = pre_pkg::MIN_LENGTH_RST;
			out_limit = pre_pkg::OUTPUT_LIMIT_RST;
			held      = 0;
			passing   = 0;
			emitted   = '0;
			stopped   = 0;
			errors    = 0;
		endfunction

		function void set_reg(logic [pre_pkg::CFG_IDX_W-1:0] idx, logic [31:0] val);
			if (idx == pre_pkg::CFG_MIN_LENGTH) begin
				min_len = val[4:0];
			end else begin
				out_limit = val;
			end
		endfunction

		// effective minimum: zero acts as one, clipped to the hold depth
		function int unsigned floor_len();
			if (min_len == 0) return 1;
			if (min_len > HOLD_DEPTH) return HOLD_DEPTH;
			return min_len;
		endfunction

		function void emit(logic [7:0] b, bit has);
			pre_pkg::result_t r;
			r.out_byte      = has ? b : 8'h00;
			r.has_byte      = has;
			r.last_of_item  = 1'b0;
			r.end_of_stream = 1'b0;
			this_item.push_back(r);
			if (has && emitted != {33{1'b1}}) emitted++;
		endfunction

		function void take_request(pre_pkg::item_t it);
			string            note;
			bit               is_text;
			bit               ends_stream;
			pre_pkg::result_t r;
			note        = "\n[Truncated - File too large]\n";
			ends_stream = 0;
			if (stopped) return;
			if (it.kind) begin
				// end of file: closing newline or empty marker
				if (passing) emit(pre_pkg::CHAR_NL, 1);
				if (this_item.size() == 0) emit(8'h00, 0);
				ends_stream = 1;
				stopped     = 1;
				held        = 0;
				passing     = 0;
			end else begin
				is_text = (it.data >= 8'h20 && it.data <= 8'h7E) ||
					it.data == pre_pkg::CHAR_NL || it.data == pre_pkg::CHAR_TAB;
				if (is_text) begin
					if (passing) begin
						emit(it.data, 1);
					end else if (held + 1 >= floor_len() || held >= HOLD_DEPTH) begin
						for (int i = 0; i < held; i++) emit(head[i], 1);
						emit(it.data, 1);
						held    = 0;
						passing = 1;
					end else begin
						head[held] = it.data;
						held++;
					end
				end else begin
					if (passing) begin
						emit(pre_pkg::CHAR_NL, 1);
						if (emitted > {1'b0, out_limit}) begin
							for (int i = 0; i < note.len(); i++) emit(note[i], 1);
							ends_stream = 1;
							stopped     = 1;
						end
					end
					held    = 0;
					passing = 0;
				end
			end
			foreach (this_item[k]) begin
				r = this_item[k];
				if (k == this_item.size() - 1) begin
					r.last_of_item  = 1'b1;
					r.end_of_stream = ends_stream;
				end
				pending_results.push_back(r);
			end
			this_item.delete();
		endfunction

		function void check_result(pre_pkg::result_t got);
			pre_pkg::result_t exp;
			if (pending_results.size() == 0) begin
				$error("unexpected result request: out_byte %0h has_byte %0b",
					got.out_byte, got.has_byte);
				errors++;
				return;
			end
			exp = pending_results.pop_front();
			if (got.out_byte !== exp.out_byte) begin
				$error("out_byte: expected %0h, got %0h", exp.out_byte, got.out_byte);
				errors++;
			end
			if (got.has_byte !== exp.has_byte) begin
				$error("has_byte: expected %0b, got %0b", exp.has_byte, got.has_byte);
				errors++;
			end
			if (got.last_of_item !== exp.last_of_item) begin
				$error("last_of_item: expected %0b, got %0b",
					exp.last_of_item, got.last_of_item);
				errors++;
			end
			if (got.end_of_stream !== exp.end_of_stream) begin
				$error("end_of_stream: expected %0b, got %0b",
					exp.end_of_stream, got.end_of_stream);
				errors++;
			end
		endfunction
	endclass

	logic                           clk = 1'b0;
	logic                           arst_n;
	logic                           push;
	logic                           full;
	pre_pkg::item_t                 item;
	logic                           empty;
	logic                           pop;
	pre_pkg::result_t               result;
	logic                           cfg_we;
	logic [pre_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [pre_pkg::CFG_DATA_W-1:0] cfg_data;

	run_scoreboard board = new();
	int            idle_cycles = 0;
	int            burst_left  = 0;
	int            sent        = 0;

	printable_run_extractor_top u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.item      (item),
		.empty     (empty),
		.pop       (pop),
		.result    (result),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	// Sender: bursts of random length; a third of bursts start with no gap.
	// Drive at the falling edge, count acceptance at the rising edge.
	task automatic feed(input logic k, input logic [7:0] d);
		pre_pkg::item_t it;
		int             gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				@(negedge clk);
				push = 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
		burst_left--;
		it.kind = k;
		it.data = d;
		@(negedge clk);
		push = 1'b1;
		item = it;
		do @(posedge clk); while (full);
		board.take_request(it);
		sent++;
	endtask

	// Text byte: mostly printable, sometimes tab or newline
	function automatic logic [7:0] text_byte();
		case ($urandom_range(0, 9))
			0:       return pre_pkg::CHAR_TAB;
			1:       return pre_pkg::CHAR_NL;
			default: return 8'($urandom_range(8'h20, 8'h7E));
		endcase
	endfunction

	// Non-text byte from the three gaps around the text ranges
	function automatic logic [7:0] junk_byte();
		case ($urandom_range(0, 2))
			0:       return 8'($urandom_range(8'h00, 8'h08));
			1:       return 8'($urandom_range(8'h0B, 8'h1F));
			default: return 8'($urandom_range(8'h7F, 8'hFF));
		endcase
	endfunction

	task automatic send_run(input int unsigned len, input bit close);
		for (int i = 0; i < len; i++) feed(1'b0, text_byte());
		if (close) feed(1'b0, junk_byte());
	endtask

	// Drop push, let every expected result drain, then give quiet requests time
	task automatic settle();
		@(negedge clk);
		push       = 1'b0;
		burst_left = 0;
		while (board.pending_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYC) @(posedge clk);
	endtask

	task automatic write_reg(input logic [pre_pkg::CFG_IDX_W-1:0] idx,
		input logic [31:0] val);
		@(negedge clk);
		cfg_we    = 1'b1;
		cfg_index = idx;
		cfg_data  = val;
		@(negedge clk);
		cfg_we    = 1'b0;
		board.set_reg(idx, val);
	endtask

	// Receiver: stall pattern switches among free run, coin flip, one in three
	// and a slow one in eight, each for a random stretch.
	initial begin : receiver
		int mode;
		int left;
		pop  = 1'b0;
		mode = 0;
		left = 0;
		forever begin
			@(negedge clk);
			if (left == 0) begin
				mode = $urandom_range(0, 3);
				left = $urandom_range(16, 80);
			end
			left--;
			case (mode)
				0:       pop = 1'b1;
				1:       pop = ($urandom_range(0, 1) == 0);
				2:       pop = (left % 3 == 0);
				default: pop = ($urandom_range(0, 7) == 0);
			endcase
		end
	end

	// Result check at the rising edge
	always @(posedge clk) begin
		if (arst_n && pop && !empty) board.check_result(result);
	end

	// Watchdog: nothing accepted on either side for too long
	always @(posedge clk) begin
		if (!arst_n || (push && !full) || (pop && !empty)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
		if (idle_cycles >= STALL_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	initial begin : stimulus
		int          mins[5];
		int          phase;
		int          quota;
		int          guard;
		int unsigned lim;
		mins      = '{1, 16, 31, 0, 2};
		arst_n    = 1'b0;
		push      = 1'b0;
		item      = '0;
		cfg_we    = 1'b0;
		cfg_index = pre_pkg::CFG_MIN_LENGTH;
		cfg_data  = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed, reset settings (minimum 4): short run dropped quietly
		feed(1'b0, 8'h61);
		feed(1'b0, 8'h62);
		feed(1'b0, 8'h63);
		feed(1'b0, 8'h00);
		// run of space, tilde, tab, newline released as a burst, then pass-through
		feed(1'b0, 8'h20);
		feed(1'b0, 8'h7E);
		feed(1'b0, pre_pkg::CHAR_TAB);
		feed(1'b0, pre_pkg::CHAR_NL);
		feed(1'b0, 8'h5A);
		feed(1'b0, 8'h1F);
		// non-text bytes outside a run give nothing
		feed(1'b0, 8'h7F);
		feed(1'b0, 8'hFF);
		feed(1'b0, 8'h80);

		// minimum of zero behaves as one
		settle();
		write_reg(pre_pkg::CFG_MIN_LENGTH, 32'd0);
		feed(1'b0, 8'h71);
		feed(1'b0, 8'h00);

		// minimum lowered mid run: held head goes out with the next byte
		settle();
		write_reg(pre_pkg::CFG_MIN_LENGTH, 32'd8);
		feed(1'b0, 8'h61);
		feed(1'b0, 8'h62);
		feed(1'b0, 8'h63);
		settle();
		write_reg(pre_pkg::CFG_MIN_LENGTH, 32'd3);
		feed(1'b0, 8'h64);
		feed(1'b0, 8'h01);

		// Random phases; the limit stays well above anything emitted here
		phase = 0;
		while (sent < 110) begin
			settle();
			write_reg(pre_pkg::CFG_MIN_LENGTH,
				(phase < 5) ? mins[phase] : $urandom_range(0, 31));
			case (phase % 3)
				0:       write_reg(pre_pkg::CFG_OUTPUT_LIMIT, 32'hFFFF_FFFF);
				1:       write_reg(pre_pkg::CFG_OUTPUT_LIMIT, pre_pkg::OUTPUT_LIMIT_RST);
				default: write_reg(pre_pkg::CFG_OUTPUT_LIMIT,
					$urandom_range(4096, 32'hFFFF_FFFE));
			endcase
			quota = sent + $urandom_range(15, 30);
			while (sent < quota) begin
				if ($urandom_range(0, 9) < 8) begin
					// phase may end mid run, so the next minimum hits held bytes
					send_run($urandom_range(0, board.floor_len() + 4),
						$urandom_range(0, 3) != 0);
				end else begin
					feed(1'b0, 8'($urandom_range(0, 255)));
				end
			end
			phase++;
		end

		// Ending: either truncation or end of file, then requests after the stop
		settle();
		if ($urandom_range(0, 1) == 0) begin
			if ($urandom_range(0, 1) == 0) begin
				lim = 0;
			end else begin
				lim = $urandom_range(0, int'(board.emitted) + 40);
			end
			write_reg(pre_pkg::CFG_OUTPUT_LIMIT, lim);
			guard = 0;
			while (!board.stopped && guard < 40) begin
				send_run(board.floor_len() + $urandom_range(0, 4), 1'b1);
				guard++;
			end
		end else begin
			// limit sometimes dropped below the count: the end-of-file flush must not truncate
			if ($urandom_range(0, 1) == 0) write_reg(pre_pkg::CFG_OUTPUT_LIMIT, 32'd0);
			send_run($urandom_range(0, board.floor_len() + 3), 1'b0);
			feed(1'b1, 8'($urandom_range(0, 255)));
		end
		feed(1'b1, 8'($urandom_range(0, 255)));
		feed(1'b0, text_byte());
		feed(1'b0, junk_byte());
		feed(1'b0, 8'($urandom_range(0, 255)));

		@(negedge clk);
		push = 1'b0;
		while (board.pending_results.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		if (board.errors == 0 && board.pending_results.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule

>>> files.f
hw/rtl/pre_pkg.sv
hw/rtl/pre_front.sv
hw/rtl/pre_cmd_queue.sv
hw/rtl/pre_back.sv
hw/rtl/printable_run_extractor_top.sv
tb/printable_run_extractor_top_test.sv
